[rtl/core/dbr_pkg.sv]
// package for the determinative run bracketer
// holds item types, bracket mode codes, code constants and the private-use map
// no dependencies
`timescale 1ns / 1ps

package dbr_pkg;

  localparam int unsigned CpWidth = 21;
  localparam int unsigned DataWidth = 24;

  typedef logic [CpWidth-1:0] cp_t;

  typedef enum logic [1:0] {
    MODE_OUT  = 2'd0,
    MODE_RUN  = 2'd1,
    MODE_TAIL = 2'd2
  } mode_e;

  typedef struct packed {
    cp_t  cp;
    logic err;
  } item_t;

  typedef struct packed {
    item_t item;
    logic  last;
  } slot_t;

  localparam cp_t PuaFirst   = 21'h00E000;
  localparam cp_t PuaLast    = 21'h00E031;
  localparam cp_t PuaLetterZ = 21'h00E019;
  localparam cp_t PuaAccent0 = 21'h00E01A;
  localparam cp_t PuaSub0    = 21'h00E027;
  localparam cp_t PuaSub9    = 21'h00E030;
  localparam cp_t SubDigit0  = 21'h002080;
  localparam cp_t LetterA    = 21'h000061;

  localparam cp_t BraceOpen  = 21'h00007B;
  localparam cp_t BraceClose = 21'h00007D;
  localparam cp_t Apostrophe = 21'h000027;
  localparam cp_t FlagHash   = 21'h000023;
  localparam cp_t FlagStar   = 21'h00002A;
  localparam cp_t FlagQuery  = 21'h00003F;
  localparam cp_t FlagBang   = 21'h000021;

  function automatic cp_t accent_cp(input logic [3:0] idx);
    cp_t res;
    case (idx)
      4'd0:    res = 21'h0000E0;
      4'd1:    res = 21'h0000E1;
      4'd2:    res = 21'h0000E8;
      4'd3:    res = 21'h0000E9;
      4'd4:    res = 21'h0000EC;
      4'd5:    res = 21'h0000ED;
      4'd6:    res = 21'h0000F9;
      4'd7:    res = 21'h0000FA;
      4'd8:    res = 21'h00014B;
      4'd9:    res = 21'h000161;
      4'd10:   res = 21'h001E2B;
      4'd11:   res = 21'h001E63;
      4'd12:   res = 21'h001E6D;
      default: res = 21'h0000E0;
    endcase
    return res;
  endfunction

  // maps one private-use code point; the unmapped one keeps its value and sets err
  function automatic item_t map_pua(input cp_t cp);
    item_t res;
    cp_t   off;
    off = cp - PuaAccent0;
    if (cp <= PuaLetterZ) begin
      res.cp  = cp - PuaFirst + LetterA;
      res.err = 1'b0;
    end else if (cp >= PuaSub0 && cp <= PuaSub9) begin
      res.cp  = cp - PuaSub0 + SubDigit0;
      res.err = 1'b0;
    end else if (cp < PuaSub0) begin
      res.cp  = accent_cp(off[3:0]);
      res.err = 1'b0;
    end else begin
      res.cp  = cp;
      res.err = 1'b1;
    end
    return res;
  endfunction

endpackage

[rtl/core/determinative_run_bracketer.sv]
// determinative run bracketer: braces runs of private-use code points and maps them back
// depends on dbr_pkg
// an item passes the input register before its results go into the result buffer
// throughput: one item per cycle when it gives one result and the receiver is ready,
//   fewer for two results, set by the one result port draining the two-entry buffer
// a third character of a step waits in the hold register and leaves with the next item
// reset clears bracket mode, hold register, input register and result buffer
`timescale 1ns / 1ps

module determinative_run_bracketer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [20:0] code_point, [23:21] zero
  input  logic        s_axis_tlast_i,   // end_of_text
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] out_code_point, [23:21] zero
  output logic        m_axis_tuser_o,   // unknown_private_use
  output logic        m_axis_tlast_o    // last_of_item
);

  // input register
  logic          in_valid_q, in_valid_d;
  dbr_pkg::cp_t  in_cp_q;
  logic          in_eot_q;

  // step state
  dbr_pkg::mode_e mode_q, mode_d;
  logic           held_valid_q, held_valid_d;
  dbr_pkg::item_t held_q, held_d;

  // result buffer
  dbr_pkg::slot_t buf_q [2];
  dbr_pkg::slot_t buf_d [2];
  logic [1:0]     cnt_q, cnt_d;

  logic s_fire, m_fire, step_fire;

  // step outputs
  dbr_pkg::item_t q [3];
  logic [1:0]     n;
  logic [1:0]     emit;
  dbr_pkg::mode_e step_mode;
  logic           is_pua, is_flag, open_run;

  assign m_fire    = m_axis_tvalid_o && m_axis_tready_i;
  assign step_fire = in_valid_q && ((cnt_q == 2'd0) || (cnt_q == 2'd1 && m_fire));
  assign s_axis_tready_o = !in_valid_q || step_fire;
  assign s_fire    = s_axis_tvalid_i && s_axis_tready_o;

  assign is_pua  = (in_cp_q >= dbr_pkg::PuaFirst) && (in_cp_q <= dbr_pkg::PuaLast);
  assign is_flag = (in_cp_q == dbr_pkg::FlagHash) || (in_cp_q == dbr_pkg::FlagStar) ||
                   (in_cp_q == dbr_pkg::FlagQuery) || (in_cp_q == dbr_pkg::FlagBang);

  always_comb begin
    case (mode_q)
      dbr_pkg::MODE_RUN:  open_run = 1'b1;
      dbr_pkg::MODE_TAIL: open_run = 1'b1;
      default:            open_run = 1'b0;
    endcase
  end

  // build the characters of one step in order, at most three
  always_comb begin
    q[0] = '0;
    q[1] = '0;
    q[2] = '0;
    n    = 2'd0;
    step_mode = dbr_pkg::MODE_OUT;
    if (held_valid_q) begin
      q[0] = held_q;
      n    = 2'd1;
    end
    if (in_eot_q) begin
      if (open_run) begin
        q[n] = '{cp: dbr_pkg::BraceClose, err: 1'b0};
        n    = n + 2'd1;
      end
      step_mode = dbr_pkg::MODE_OUT;
    end else if (is_pua) begin
      if (!open_run) begin
        q[n] = '{cp: dbr_pkg::BraceOpen, err: 1'b0};
        n    = n + 2'd1;
      end else if (mode_q == dbr_pkg::MODE_TAIL) begin
        q[n] = '{cp: dbr_pkg::BraceClose, err: 1'b0};
        n    = n + 2'd1;
        q[n] = '{cp: dbr_pkg::BraceOpen, err: 1'b0};
        n    = n + 2'd1;
      end
      q[n] = dbr_pkg::map_pua(in_cp_q);
      n    = n + 2'd1;
      step_mode = dbr_pkg::MODE_RUN;
    end else if (open_run && is_flag) begin
      q[n] = '{cp: in_cp_q, err: 1'b0};
      n    = n + 2'd1;
      step_mode = dbr_pkg::MODE_TAIL;
    end else if (open_run) begin
      q[n] = '{cp: dbr_pkg::BraceClose, err: 1'b0};
      n    = n + 2'd1;
      // apostrophe right after the closing brace is dropped
      if (in_cp_q != dbr_pkg::Apostrophe) begin
        q[n] = '{cp: in_cp_q, err: 1'b0};
        n    = n + 2'd1;
      end
      step_mode = dbr_pkg::MODE_OUT;
    end else begin
      q[n] = '{cp: in_cp_q, err: 1'b0};
      n    = n + 2'd1;
      step_mode = dbr_pkg::MODE_OUT;
    end
    emit = (n == 2'd3) ? 2'd2 : n;
  end

  always_comb begin
    in_valid_d   = in_valid_q;
    mode_d       = mode_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    buf_d[0]     = buf_q[0];
    buf_d[1]     = buf_q[1];
    cnt_d        = cnt_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (step_fire) begin
      in_valid_d = 1'b0;
    end
    if (step_fire) begin
      // buffer is empty after this edge's transfer, so load from the front
      mode_d       = step_mode;
      held_valid_d = (n == 2'd3);
      held_d       = q[2];
      buf_d[0]     = '{item: q[0], last: (emit == 2'd1)};
      buf_d[1]     = '{item: q[1], last: 1'b1};
      cnt_d        = emit;
    end else if (m_fire) begin
      buf_d[0] = buf_q[1];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q   <= 1'b0;
      mode_q       <= dbr_pkg::MODE_OUT;
      held_valid_q <= 1'b0;
      cnt_q        <= 2'd0;
    end else begin
      in_valid_q   <= in_valid_d;
      mode_q       <= mode_d;
      held_valid_q <= held_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_cp_q  <= s_axis_tdata_i[dbr_pkg::CpWidth-1:0];
      in_eot_q <= s_axis_tlast_i;
    end
    held_q   <= held_d;
    buf_q[0] <= buf_d[0];
    buf_q[1] <= buf_d[1];
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {{(dbr_pkg::DataWidth - dbr_pkg::CpWidth){1'b0}}, buf_q[0].item.cp};
  assign m_axis_tuser_o  = buf_q[0].item.err;
  assign m_axis_tlast_o  = buf_q[0].last;

endmodule

[rtl/core/dbr_checker.sv]
// port-level checker for the determinative run bracketer, with its bind
// depends on dbr_pkg and determinative_run_bracketer
`timescale 1ns / 1ps

module dbr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [23:0] s_axis_tdata_i,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [23:0] m_axis_tdata_o,
  input logic        m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  // only the unmapped private-use code point carries the error flag
  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |->
      (m_axis_tdata_o[20:0] == dbr_pkg::PuaLast))
    else $error("error flag on a character other than the unmapped one");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[23:21] == 3'b000))
    else $error("padding bits of result data not zero");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=>
      ($stable(m_axis_tdata_o) && $stable(m_axis_tuser_o) && $stable(m_axis_tlast_o)))
    else $error("result changed while stalled");

endmodule

bind determinative_run_bracketer dbr_checker u_dbr_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .s_axis_tlast_i  (s_axis_tlast_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

[tb/tb_determinative_run_bracketer.sv]
// self-checking testbench for determinative_run_bracketer
// drives code points through the input stream and checks every result transfer against
// typed rows or an in-bench bracketing model; depends on dbr_pkg, determinative_run_bracketer
`timescale 1ns / 1ps

module tb_determinative_run_bracketer;

  localparam int unsigned RandomItems = 1700;
  localparam int unsigned DrainEvery  = 400;
  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned PlanRows    = 26;
  localparam logic [1:0]  Predicted   = 2'd3;

  // accented letters in private-use order, entry 0 in the low bits
  localparam logic [12:0][20:0] AccentTab = {
    21'h001E6D, 21'h001E63, 21'h001E2B, 21'h000161, 21'h00014B, 21'h0000FA, 21'h0000F9,
    21'h0000ED, 21'h0000EC, 21'h0000E9, 21'h0000E8, 21'h0000E1, 21'h0000E0
  };

  typedef struct packed {
    logic           eot;
    dbr_pkg::cp_t   cp;
    logic [1:0]     n;
    dbr_pkg::item_t r0;
    dbr_pkg::item_t r1;
  } row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid_i;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i;   // [20:0] code_point, [23:21] zero
  logic        s_axis_tlast_i;   // end_of_text
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i;
  logic [23:0] m_axis_tdata_o;   // [20:0] out_code_point, [23:21] zero
  logic        m_axis_tuser_o;   // unknown_private_use
  logic        m_axis_tlast_o;   // last_of_item

  dbr_pkg::slot_t due_chars[$];
  dbr_pkg::slot_t step_chars[$];
  dbr_pkg::slot_t typed_chars[$];
  logic           use_typed;
  dbr_pkg::mode_e run_mode;
  logic           held_ok;
  dbr_pkg::item_t held_chr;
  int unsigned    burst_left;
  logic           valid_up;
  int unsigned    sent;
  int unsigned    faults = 0;
  int unsigned    cycles = 0;
  row_t           plan [PlanRows];

  determinative_run_bracketer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic dbr_pkg::item_t plain(input dbr_pkg::cp_t cp);
    dbr_pkg::item_t r;
    r.cp  = cp;
    r.err = 1'b0;
    return r;
  endfunction

  function automatic dbr_pkg::item_t unmap_pua(input dbr_pkg::cp_t cp);
    dbr_pkg::item_t r;
    dbr_pkg::cp_t   off;
    r   = plain(cp);
    off = cp - dbr_pkg::PuaAccent0;
    if (cp <= dbr_pkg::PuaLetterZ) begin
      r.cp = cp - dbr_pkg::PuaFirst + dbr_pkg::LetterA;
    end else if (cp >= dbr_pkg::PuaSub0 && cp <= dbr_pkg::PuaSub9) begin
      r.cp = cp - dbr_pkg::PuaSub0 + dbr_pkg::SubDigit0;
    end else if (cp < dbr_pkg::PuaSub0) begin
      r.cp = AccentTab[off[3:0]];
    end else begin
      r.err = 1'b1;
    end
    return r;
  endfunction

  // works out the characters one accepted item releases, keeping the third one back
  task automatic bracket_predict(input dbr_pkg::cp_t cp, input logic eot);
    dbr_pkg::item_t pend[$];
    dbr_pkg::slot_t s;
    int             emit;
    pend = {};
    if (held_ok) begin
      pend.push_back(held_chr);
      held_ok = 1'b0;
    end
    if (eot) begin
      if (run_mode != dbr_pkg::MODE_OUT) pend.push_back(plain(dbr_pkg::BraceClose));
      run_mode = dbr_pkg::MODE_OUT;
    end else if (cp >= dbr_pkg::PuaFirst && cp <= dbr_pkg::PuaLast) begin
      if (run_mode == dbr_pkg::MODE_OUT) begin
        pend.push_back(plain(dbr_pkg::BraceOpen));
      end else if (run_mode == dbr_pkg::MODE_TAIL) begin
        pend.push_back(plain(dbr_pkg::BraceClose));
        pend.push_back(plain(dbr_pkg::BraceOpen));
      end
      pend.push_back(unmap_pua(cp));
      run_mode = dbr_pkg::MODE_RUN;
    end else if (run_mode != dbr_pkg::MODE_OUT &&
                 (cp == dbr_pkg::FlagHash || cp == dbr_pkg::FlagStar ||
                  cp == dbr_pkg::FlagQuery || cp == dbr_pkg::FlagBang)) begin
      pend.push_back(plain(cp));
      run_mode = dbr_pkg::MODE_TAIL;
    end else if (run_mode != dbr_pkg::MODE_OUT) begin
      pend.push_back(plain(dbr_pkg::BraceClose));
      if (cp != dbr_pkg::Apostrophe) pend.push_back(plain(cp));
      run_mode = dbr_pkg::MODE_OUT;
    end else begin
      pend.push_back(plain(cp));
    end
    if (pend.size() > 2) begin
      held_ok  = 1'b1;
      held_chr = pend[2];
    end
    emit = (pend.size() > 2) ? 2 : pend.size();
    step_chars = {};
    for (int k = 0; k < emit; k++) begin
      s.item = pend[k];
      s.last = (k == emit - 1);
      step_chars.push_back(s);
    end
  endtask

  task automatic send_item(input dbr_pkg::cp_t cp, input logic eot);
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, cp};
    s_axis_tlast_i  <= eot;
    valid_up = 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bracket_predict(cp, eot);
    if (use_typed) begin
      foreach (typed_chars[k]) due_chars.push_back(typed_chars[k]);
    end else begin
      foreach (step_chars[k]) due_chars.push_back(step_chars[k]);
    end
    use_typed = 1'b0;
    sent++;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      valid_up = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                               : $urandom_range(1, 12);
    end
  endtask

  // sender holds off until every expected character is out and the pipe has settled
  task automatic drain(input int unsigned settle);
    if (valid_up) begin
      s_axis_tvalid_i <= 1'b0;
      valid_up = 1'b0;
    end
    while (due_chars.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  function automatic dbr_pkg::cp_t flag_pick();
    dbr_pkg::cp_t c;
    case ($urandom_range(0, 3))
      0:       c = dbr_pkg::FlagHash;
      1:       c = dbr_pkg::FlagStar;
      2:       c = dbr_pkg::FlagQuery;
      default: c = dbr_pkg::FlagBang;
    endcase
    return c;
  endfunction

  function automatic dbr_pkg::cp_t plain_pick();
    dbr_pkg::cp_t c;
    case ($urandom_range(0, 5))
      0:       c = dbr_pkg::cp_t'($urandom);   // all 21 bits, also past 0x10FFFF
      1:       c = dbr_pkg::cp_t'($urandom_range(32, 126));
      2:       c = dbr_pkg::Apostrophe;
      3:       c = dbr_pkg::cp_t'($urandom_range(dbr_pkg::PuaFirst - 4,
                                                 dbr_pkg::PuaLast + 4));
      4:       c = flag_pick();
      default: c = dbr_pkg::cp_t'($urandom_range(0, 21'h10FFFF));
    endcase
    return c;
  endfunction

  // mostly runs, each with an optional flag tail and closer, the rest loose characters
  task automatic send_word();
    int unsigned len;
    if ($urandom_range(0, 9) <= 5) begin
      len = $urandom_range(1, 4);
      repeat (len) begin
        send_item(dbr_pkg::cp_t'($urandom_range(dbr_pkg::PuaFirst, dbr_pkg::PuaLast)),
                  1'b0);
      end
      len = $urandom_range(0, 3);
      repeat (len) send_item(flag_pick(), 1'b0);
      case ($urandom_range(0, 3))
        0:       send_item(dbr_pkg::Apostrophe, 1'b0);
        1:       send_item(plain_pick(), 1'b0);
        2:       send_item(dbr_pkg::cp_t'($urandom), 1'b1);
        default: ;
      endcase
    end else if ($urandom_range(0, 4) != 0) begin
      send_item(plain_pick(), 1'b0);
    end else begin
      send_item(dbr_pkg::cp_t'($urandom), 1'b1);
    end
  endtask

  function automatic row_t row(input logic eot, input dbr_pkg::cp_t cp, input logic [1:0] n,
                               input dbr_pkg::cp_t c0 = '0, input logic e0 = 1'b0,
                               input dbr_pkg::cp_t c1 = '0, input logic e1 = 1'b0);
    row_t r;
    r.eot    = eot;
    r.cp     = cp;
    r.n      = n;
    r.r0.cp  = c0;
    r.r0.err = e0;
    r.r1.cp  = c1;
    r.r1.err = e1;
    return r;
  endfunction

  initial begin
    plan[0]  = row(1'b0, 21'h000000, 2'd1, 21'h000000);
    plan[1]  = row(1'b0, 21'h1FFFFF, 2'd1, 21'h1FFFFF);
    plan[2]  = row(1'b1, 21'h1FFFFF, 2'd0);                  // end of text, nothing open
    plan[3]  = row(1'b0, dbr_pkg::PuaFirst, 2'd2, dbr_pkg::BraceOpen, 1'b0,
                   dbr_pkg::LetterA, 1'b0);
    plan[4]  = row(1'b0, dbr_pkg::PuaLetterZ, 2'd1, 21'h00007A);
    plan[5]  = row(1'b0, dbr_pkg::PuaAccent0, 2'd1, 21'h0000E0);
    plan[6]  = row(1'b0, 21'h00E026, 2'd1, 21'h001E6D);
    plan[7]  = row(1'b0, dbr_pkg::PuaSub0, 2'd1, dbr_pkg::SubDigit0);
    plan[8]  = row(1'b0, dbr_pkg::PuaSub9, 2'd1, 21'h002089);
    // unmapped one flags an error
    plan[9]  = row(1'b0, dbr_pkg::PuaLast, 2'd1, dbr_pkg::PuaLast, 1'b1);
    plan[10] = row(1'b0, dbr_pkg::FlagHash, Predicted);
    plan[11] = row(1'b0, dbr_pkg::FlagStar, Predicted);
    plan[12] = row(1'b0, 21'h00E005, Predicted);             // flag tail then new run: one held
    plan[13] = row(1'b0, dbr_pkg::FlagQuery, Predicted);
    plan[14] = row(1'b0, dbr_pkg::FlagBang, Predicted);
    plan[15] = row(1'b0, dbr_pkg::Apostrophe, Predicted);    // apostrophe after tail dropped
    plan[16] = row(1'b0, 21'h00DFFF, Predicted);
    plan[17] = row(1'b0, 21'h00E032, Predicted);
    plan[18] = row(1'b0, 21'h00E010, Predicted);
    plan[19] = row(1'b0, 21'h000041, Predicted);             // plain letter closes the run
    plan[20] = row(1'b0, 21'h00E001, Predicted);
    plan[21] = row(1'b0, dbr_pkg::FlagHash, Predicted);
    plan[22] = row(1'b0, dbr_pkg::PuaLast, Predicted);       // error character waits in hold
    plan[23] = row(1'b1, 21'h000000, Predicted);             // end of text flushes hold, closes
    plan[24] = row(1'b0, 21'h00E020, Predicted);
    plan[25] = row(1'b1, 21'h1FFFFF, Predicted);

    run_mode   = dbr_pkg::MODE_OUT;
    held_ok    = 1'b0;
    held_chr   = '0;
    use_typed  = 1'b0;
    valid_up   = 1'b0;
    sent       = 0;
    burst_left = $urandom_range(1, 12);
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tlast_i  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < PlanRows; i++) begin
      typed_chars = {};
      if (plan[i].n != Predicted) begin
        if (plan[i].n >= 2'd1) typed_chars.push_back({plan[i].r0, plan[i].n == 2'd1});
        if (plan[i].n == 2'd2) typed_chars.push_back({plan[i].r1, 1'b1});
        use_typed = 1'b1;
      end
      send_item(plan[i].cp, plan[i].eot);
    end
    drain(4);

    while (sent < PlanRows + RandomItems) begin
      send_word();
      if (sent % DrainEvery < 4 && $urandom_range(0, 3) == 0) drain(4);
    end
    send_item(21'h000000, 1'b1);   // flush anything still held
    drain(20);

    if (faults == 0) begin
      $display("determinative_run_bracketer: match");
    end else begin
      $display("determinative_run_bracketer: mismatch");
    end
    $finish;
  end

  // receiver stall patterns: open, coin flip, mostly stalled, toggling
  initial begin
    int unsigned style;
    int unsigned len;
    m_axis_tready_i <= 1'b0;
    forever begin
      style = $urandom_range(0, 3);
      len   = $urandom_range(1, 40);
      repeat (len) begin
        @(posedge clk_i);
        case (style)
          0:       m_axis_tready_i <= 1'b1;
          1:       m_axis_tready_i <= ($urandom_range(0, 1) == 1);
          2:       m_axis_tready_i <= ($urandom_range(0, 3) == 0);
          default: m_axis_tready_i <= ~m_axis_tready_i;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : check_out
    dbr_pkg::slot_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (due_chars.size() == 0) begin
        $display("%0t: unexpected transfer tdata=%h tuser=%b tlast=%b",
                 $time, m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
        faults++;
      end else begin
        want = due_chars.pop_front();
        if (m_axis_tdata_o !== {3'b000, want.item.cp} || m_axis_tuser_o !== want.item.err ||
            m_axis_tlast_o !== want.last) begin
          $display("%0t: expected cp=%h err=%b last=%b, got tdata=%h tuser=%b tlast=%b",
                   $time, want.item.cp, want.item.err, want.last,
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          faults++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("determinative_run_bracketer: mismatch");
      $finish;
    end
  end

endmodule
